// ----- sv/adx_pkg.sv -----
// adx_pkg: shared widths and constants for the average directional index block
// depends on nothing; imported by both interfaces, the divider and the top level
package adx_pkg;
   localparam int PRICE_BITS = 24;
   localparam int SUM_BITS   = 40;
   localparam int PCT_BITS   = 23;
   localparam int CNT_BITS   = 7;
   localparam int DVD_BITS   = 64;
   localparam int DVS_BITS   = 40;
   localparam int DXSUM_BITS = 30;

   localparam logic [PCT_BITS-1:0] PCT_FULL = 23'd6553600;
   localparam logic [CNT_BITS-1:0] CNT_MAX  = 7'd127;
   localparam logic [CNT_BITS-1:0] PERIOD_RESET = 7'd14;
   localparam logic [CNT_BITS-1:0] PERIOD_MIN   = 7'd2;

   typedef logic [PRICE_BITS-1:0] price_type;
   typedef logic [SUM_BITS-1:0]   sum_type;
   typedef logic [PCT_BITS-1:0]   pct_type;
endpackage

// ----- sv/adx_req_if.sv -----
// adx_req_if: price bar channel with valid/ready handshake
// depends on adx_pkg for the price type
interface adx_req_if;
   import adx_pkg::*;
   logic      valid;
   logic      ready;
   price_type high_price;
   price_type low_price;
   price_type close_price;
   modport source (output valid, high_price, low_price, close_price, input ready);
   modport sink   (input valid, high_price, low_price, close_price, output ready);
endinterface

// ----- sv/adx_rsp_if.sv -----
// adx_rsp_if: indicator result channel with valid/ready handshake
// depends on adx_pkg for the percent type
interface adx_rsp_if;
   import adx_pkg::*;
   logic    valid;
   logic    ready;
   pct_type adx_value;
   pct_type dx_value;
   pct_type plus_di;
   pct_type minus_di;
   logic    adx_valid;
   modport source (output valid, adx_value, dx_value, plus_di, minus_di, adx_valid,
                   input ready);
   modport sink   (input valid, adx_value, dx_value, plus_di, minus_di, adx_valid,
                   output ready);
endinterface

// ----- sv/adx_div.sv -----
// adx_div: restoring divider, one quotient bit per cycle
// depends on adx_pkg for operand widths
module adx_div
   import adx_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DVD_BITS-1:0] dividend,
   input  logic [DVS_BITS-1:0] divisor,
   output logic                done,
   output logic [DVD_BITS-1:0] quotient
);
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [5:0]          count_ff, count_in;
   logic [DVD_BITS-1:0] work_ff, work_in;
   logic [DVS_BITS-1:0] dvs_ff, dvs_in;
   logic [DVS_BITS-1:0] rem_ff, rem_in;
   logic [DVS_BITS:0]   shifted;
   logic                fits;

   // one shift-subtract step
   always_comb begin
      shifted  = {rem_ff, work_ff[DVD_BITS-1]};
      fits     = shifted >= {1'b0, dvs_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      work_in  = work_ff;
      dvs_in   = dvs_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         work_in  = dividend;
         dvs_in   = divisor;
         rem_in   = '0;
      end else if (busy_ff) begin
         rem_in   = fits ? DVS_BITS'(shifted - {1'b0, dvs_ff}) : shifted[DVS_BITS-1:0];
         work_in  = {work_ff[DVD_BITS-2:0], fits};
         count_in = count_ff + 6'd1;
         if (count_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      work_ff  <= work_in;
      dvs_ff   <= dvs_in;
      rem_ff   <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = work_ff;
endmodule

// ----- sv/adx_trend_strength_indicator.sv -----
// adx_trend_strength_indicator: Wilder average directional index over price bars
// timing: first bar and seeding bars go from acceptance straight to the result state; later
//   bars run up to seven divisions on the shared divider
// flow: one bar at a time; the next bar is taken the cycle after the result transaction
// reset: synchronous, clears history and seeding; period returns to 14
// depends on adx_pkg, adx_req_if, adx_rsp_if and adx_div
module adx_trend_strength_indicator
   import adx_pkg::*;
#(
   parameter int MAX_PERIOD = 64
)
(
   input  logic                clock,
   input  logic                reset,
   adx_req_if.sink             req_channel,
   adx_rsp_if.source           rsp_channel,
   input  logic                csr_write_enable,
   input  logic [CNT_BITS-1:0] csr_write_data
);
   localparam int PCLAMP = (MAX_PERIOD > 127) ? 127 : MAX_PERIOD;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   localparam logic [2:0] OP_WR  = 3'd0;
   localparam logic [2:0] OP_WP  = 3'd1;
   localparam logic [2:0] OP_WM  = 3'd2;
   localparam logic [2:0] OP_DIP = 3'd3;
   localparam logic [2:0] OP_DIM = 3'd4;
   localparam logic [2:0] OP_DX  = 3'd5;
   localparam logic [2:0] OP_ACC = 3'd6;
   localparam logic [2:0] OP_ADX = 3'd7;

   // multiply by 6553600 = 25 << 18
   function automatic logic [DVD_BITS-1:0] scale_pct(input sum_type x);
      logic [SUM_BITS+4:0] t;
      t = {x, 4'b0} + {1'b0, x, 3'b0} + {5'b0, x};
      return {1'b0, t, 18'b0};
   endfunction

   function automatic pct_type sat_pct(input logic [DVD_BITS-1:0] q);
      return (q > {41'b0, PCT_FULL}) ? PCT_FULL : q[PCT_BITS-1:0];
   endfunction

   function automatic sum_type sat_sum(input logic [SUM_BITS:0] v);
      return v[SUM_BITS] ? {SUM_BITS{1'b1}} : v[SUM_BITS-1:0];
   endfunction

   // s - floor(s/p) + (x << 8), saturated
   function automatic sum_type wilder(input sum_type s, input logic [DVD_BITS-1:0] q,
                                      input price_type x);
      logic [SUM_BITS:0] v;
      v = {1'b0, s} - {1'b0, q[SUM_BITS-1:0]} + {9'b0, x, 8'b0};
      return sat_sum(v);
   endfunction

   function automatic price_type abs_diff(input price_type a, input price_type b);
      return (a > b) ? a - b : b - a;
   endfunction

   logic [1:0]          state_ff, state_in;
   logic [2:0]          op_ff, op_in;
   logic [CNT_BITS-1:0] period_ff;
   logic                have_prev_ff, have_prev_in;
   price_type           prev_high_ff, prev_high_in;
   price_type           prev_low_ff, prev_low_in;
   price_type           prev_close_ff, prev_close_in;
   logic [CNT_BITS-1:0] bar_count_ff, bar_count_in;
   logic [CNT_BITS-1:0] dx_count_ff, dx_count_in;
   sum_type             range_ff, range_in;
   sum_type             plus_ff, plus_in;
   sum_type             minus_ff, minus_in;
   price_type           tr_ff, tr_in;
   price_type           pdm_ff, pdm_in;
   price_type           mdm_ff, mdm_in;
   logic [DXSUM_BITS-1:0] dx_sum_ff, dx_sum_in;
   pct_type             adx_ff, adx_in;
   logic                ready_ff, ready_in;
   pct_type             pdi_ff, pdi_in;
   pct_type             mdi_ff, mdi_in;
   pct_type             dx_ff, dx_in;
   logic                zero_ff, zero_in;

   logic [CNT_BITS-1:0] period;
   price_type           h, l, c, tr_a, tr_b, tr_c, up, down;
   logic [CNT_BITS-1:0] bc_next, dc_next;
   logic [PCT_BITS:0]   di_sum;
   logic [PCT_BITS+CNT_BITS:0] adx_mix;
   logic                div_start, div_done;
   logic [DVD_BITS-1:0] div_dividend, div_quotient;
   logic [DVS_BITS-1:0] div_divisor;

   // clamp the period into its working range
   always_comb begin
      if (period_ff < PERIOD_MIN)                       period = PERIOD_MIN;
      else if (period_ff > CNT_BITS'(PCLAMP))           period = CNT_BITS'(PCLAMP);
      else                                              period = period_ff;
   end

   // true range and directional movement against the previous bar
   always_comb begin
      h    = req_channel.high_price;
      l    = req_channel.low_price;
      c    = req_channel.close_price;
      tr_a = abs_diff(h, l);
      tr_b = abs_diff(h, prev_close_ff);
      tr_c = abs_diff(l, prev_close_ff);
      up   = (h > prev_high_ff) ? h - prev_high_ff : '0;
      down = (prev_low_ff > l) ? prev_low_ff - l : '0;
      bc_next = (bar_count_ff < CNT_MAX) ? bar_count_ff + 7'd1 : bar_count_ff;
      dc_next = (dx_count_ff < CNT_MAX) ? dx_count_ff + 7'd1 : dx_count_ff;
      di_sum  = {1'b0, pdi_ff} + {1'b0, mdi_ff};
      adx_mix = {1'b0, (PCT_BITS+CNT_BITS)'(adx_ff) * (PCT_BITS+CNT_BITS)'(period - 7'd1)}
                + {8'b0, dx_ff};
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      have_prev_in  = have_prev_ff;
      prev_high_in  = prev_high_ff;
      prev_low_in   = prev_low_ff;
      prev_close_in = prev_close_ff;
      bar_count_in  = bar_count_ff;
      dx_count_in   = dx_count_ff;
      range_in      = range_ff;
      plus_in       = plus_ff;
      minus_in      = minus_ff;
      tr_in         = tr_ff;
      pdm_in        = pdm_ff;
      mdm_in        = mdm_ff;
      dx_sum_in     = dx_sum_ff;
      adx_in        = adx_ff;
      ready_in      = ready_ff;
      pdi_in        = pdi_ff;
      mdi_in        = mdi_ff;
      dx_in         = dx_ff;
      zero_in       = zero_ff;
      div_start     = 1'b0;
      div_dividend  = '0;
      div_divisor   = {33'b0, period};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_channel.valid) begin
               prev_high_in  = h;
               prev_low_in   = l;
               prev_close_in = c;
               if (!have_prev_ff) begin
                  have_prev_in = 1'b1;
                  zero_in      = 1'b1;
                  state_in     = ST_OUT;
               end else begin
                  tr_in  = tr_a;
                  if (tr_b > tr_in) tr_in = tr_b;
                  if (tr_c > tr_in) tr_in = tr_c;
                  pdm_in = (up > down) ? up : '0;
                  mdm_in = (down > up) ? down : '0;
                  zero_in = 1'b0;
                  if (bar_count_ff < period) begin
                     range_in     = sat_sum({1'b0, range_ff} + {9'b0, tr_in, 8'b0});
                     plus_in      = sat_sum({1'b0, plus_ff} + {9'b0, pdm_in, 8'b0});
                     minus_in     = sat_sum({1'b0, minus_ff} + {9'b0, mdm_in, 8'b0});
                     bar_count_in = bc_next;
                     if (bc_next < period) begin
                        zero_in  = 1'b1;
                        state_in = ST_OUT;
                     end else begin
                        op_in    = OP_DIP;
                        state_in = ST_ISSUE;
                     end
                  end else begin
                     op_in    = OP_WR;
                     state_in = ST_ISSUE;
                  end
               end
            end
         end
         ST_ISSUE: begin
            unique case (op_ff)
               OP_WR: begin
                  div_start = 1'b1; div_dividend = {24'b0, range_ff}; state_in = ST_WAIT;
               end
               OP_WP: begin
                  div_start = 1'b1; div_dividend = {24'b0, plus_ff}; state_in = ST_WAIT;
               end
               OP_WM: begin
                  div_start = 1'b1; div_dividend = {24'b0, minus_ff}; state_in = ST_WAIT;
               end
               OP_DIP: begin
                  if (range_ff == '0) begin
                     pdi_in = '0;
                     mdi_in = '0;
                     op_in  = OP_DX;
                  end else begin
                     div_start    = 1'b1;
                     div_dividend = scale_pct(plus_ff);
                     div_divisor  = range_ff;
                     state_in     = ST_WAIT;
                  end
               end
               OP_DIM: begin
                  div_start    = 1'b1;
                  div_dividend = scale_pct(minus_ff);
                  div_divisor  = range_ff;
                  state_in     = ST_WAIT;
               end
               OP_DX: begin
                  if (di_sum == '0) begin
                     dx_in = '0;
                     op_in = OP_ACC;
                  end else begin
                     div_start    = 1'b1;
                     div_dividend = scale_pct({17'b0, (pdi_ff > mdi_ff) ?
                                               pdi_ff - mdi_ff : mdi_ff - pdi_ff});
                     div_divisor  = {16'b0, di_sum};
                     state_in     = ST_WAIT;
                  end
               end
               OP_ACC: begin
                  if (!ready_ff) begin
                     dx_sum_in   = dx_sum_ff + {7'b0, dx_ff};
                     dx_count_in = dc_next;
                     if (dc_next >= period) op_in = OP_ADX;
                     else                   state_in = ST_OUT;
                  end else begin
                     op_in = OP_ADX;
                  end
               end
               OP_ADX: begin
                  div_start    = 1'b1;
                  div_dividend = ready_ff ? {33'b0, adx_mix} : {34'b0, dx_sum_ff};
                  state_in     = ST_WAIT;
               end
               default: ;
            endcase
         end
         ST_WAIT: begin
            if (div_done) begin
               state_in = ST_ISSUE;
               unique case (op_ff)
                  OP_WR:  begin range_in = wilder(range_ff, div_quotient, tr_ff); op_in = OP_WP; end
                  OP_WP:  begin plus_in  = wilder(plus_ff, div_quotient, pdm_ff); op_in = OP_WM; end
                  OP_WM:  begin minus_in = wilder(minus_ff, div_quotient, mdm_ff); op_in = OP_DIP; end
                  OP_DIP: begin pdi_in = sat_pct(div_quotient); op_in = OP_DIM; end
                  OP_DIM: begin mdi_in = sat_pct(div_quotient); op_in = OP_DX; end
                  OP_DX:  begin dx_in  = sat_pct(div_quotient); op_in = OP_ACC; end
                  OP_ADX: begin
                     adx_in   = sat_pct(div_quotient);
                     ready_in = 1'b1;
                     state_in = ST_OUT;
                  end
                  default: ;
               endcase
            end
         end
         ST_OUT: begin
            if (rsp_channel.ready) state_in = ST_IDLE;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= OP_WR;
         period_ff     <= PERIOD_RESET;
         have_prev_ff  <= 1'b0;
         prev_high_ff  <= '0;
         prev_low_ff   <= '0;
         prev_close_ff <= '0;
         bar_count_ff  <= '0;
         dx_count_ff   <= '0;
         range_ff      <= '0;
         plus_ff       <= '0;
         minus_ff      <= '0;
         dx_sum_ff     <= '0;
         adx_ff        <= '0;
         ready_ff      <= 1'b0;
         zero_ff       <= 1'b1;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         if (csr_write_enable) period_ff <= csr_write_data;
         have_prev_ff  <= have_prev_in;
         prev_high_ff  <= prev_high_in;
         prev_low_ff   <= prev_low_in;
         prev_close_ff <= prev_close_in;
         bar_count_ff  <= bar_count_in;
         dx_count_ff   <= dx_count_in;
         range_ff      <= range_in;
         plus_ff       <= plus_in;
         minus_ff      <= minus_in;
         dx_sum_ff     <= dx_sum_in;
         adx_ff        <= adx_in;
         ready_ff      <= ready_in;
         zero_ff       <= zero_in;
      end
      tr_ff  <= tr_in;
      pdm_ff <= pdm_in;
      mdm_ff <= mdm_in;
      pdi_ff <= pdi_in;
      mdi_ff <= mdi_in;
      dx_ff  <= dx_in;
   end

   // shared divider
   adx_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // result transaction
   assign req_channel.ready     = (state_ff == ST_IDLE);
   assign rsp_channel.valid     = (state_ff == ST_OUT);
   assign rsp_channel.adx_valid = !zero_ff && ready_ff;
   assign rsp_channel.adx_value = (!zero_ff && ready_ff) ? adx_ff : '0;
   assign rsp_channel.dx_value  = zero_ff ? '0 : dx_ff;
   assign rsp_channel.plus_di   = zero_ff ? '0 : pdi_ff;
   assign rsp_channel.minus_di  = zero_ff ? '0 : mdi_ff;
endmodule
